// File: rtl/core/drc_pkg.sv
// Shared types and constants of the door relay position controller.
// No dependencies; every other file of the core imports this package.
`default_nettype none

package drc_pkg;

    localparam int TIMER_BITS_DEFAULT = 24;
    localparam int CFG_BITS           = 24;
    localparam int S_TDATA_BITS       = 8;
    localparam int M_TDATA_BITS       = 8;

    localparam logic [CFG_BITS-1:0] RELAY_PULSE_RESET   = 24'd500;
    localparam logic [CFG_BITS-1:0] STUCK_TIMEOUT_RESET = 24'd30000;

    // Configuration register indexes
    localparam logic CFG_RELAY_PULSE   = 1'b0;
    localparam logic CFG_STUCK_TIMEOUT = 1'b1;

    // Item kinds carried in s_tuser
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    // Door command codes; anything above CMD_CLOSE is invalid
    localparam logic [1:0] CMD_OPEN  = 2'd0;
    localparam logic [1:0] CMD_CLOSE = 2'd1;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    // Switch sample, {closed, open}
    localparam logic [1:0] SW_NONE   = 2'b00;
    localparam logic [1:0] SW_OPEN   = 2'b01;
    localparam logic [1:0] SW_CLOSED = 2'b10;
    localparam logic [1:0] SW_BOTH   = 2'b11;

    typedef enum logic [1:0] {
        MODE_UNKNOWN = 2'd0,
        MODE_OPEN    = 2'd1,
        MODE_CLOSED  = 2'd2,
        MODE_MOVING  = 2'd3
    } door_mode_t;

    typedef enum logic [1:0] {
        TMR_NOTSET  = 2'd0,
        TMR_RUNNING = 2'd1,
        TMR_EXPIRED = 2'd2
    } tmr_status_t;

    typedef enum logic [1:0] {
        RESP_ACK           = 2'd0,
        RESP_NAK_INVALID   = 2'd1,
        RESP_NAK_NOT_READY = 2'd2
    } resp_t;

    // Per-timer control for one item
    typedef struct packed {
        logic advance;
        logic start;
        logic clear;
    } tmr_ctl_t;

    typedef struct packed {
        resp_t      response;
        door_mode_t door_status;
        logic       relay_drive;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/door_relay_position_controller_core.sv
// Top level of the door relay position controller: ports, configuration,
// timers and result buffer. Depends on drc_pkg, drc_timer, drc_ctrl, drc_outbuf.
`default_nettype none

// Takes one transaction per clock while s_tready is high: a tick (s_tuser
// low) carrying the switch sample, or an open/close command (s_tuser high).
// Each transaction yields exactly one result on the m_ side, registered.
// The whole decision plus the three timer updates is done in the accepting
// cycle, so the sustained rate is one transaction per cycle while m_tready
// keeps up; a two-entry output buffer holds s_tready high while one result
// waits and drops it only with two held. Timers count ticks, not clock cycles.
// The configuration port is always ready; write it only while idle.
module door_relay_position_controller_core #(
    parameter int TIMER_BITS = drc_pkg::TIMER_BITS_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [1:0] door_command, [2] open_switch, [3] closed_switch, [7:4] zero
    input  wire logic [drc_pkg::S_TDATA_BITS-1:0] s_tdata,
    // [0] operation
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [0] relay_drive, [2:1] door_status, [4:3] response, [7:5] zero
    output logic [drc_pkg::M_TDATA_BITS-1:0]   m_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_index,
    input  wire logic [drc_pkg::CFG_BITS-1:0]  cfg_data
);
    import drc_pkg::*;

    logic [CFG_BITS-1:0]   relay_pulse_reg, stuck_timeout_reg;
    logic [TIMER_BITS-1:0] pulse_load, stuck_load;
    logic                  s_accept;
    logic [1:0]            sw;
    tmr_ctl_t              pulse_ctl, stuck_ctl, lost_ctl;
    tmr_status_t           pulse_st, stuck_st, lost_st;
    result_t               result, m_result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            relay_pulse_reg   <= RELAY_PULSE_RESET;
            stuck_timeout_reg <= STUCK_TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_RELAY_PULSE:   relay_pulse_reg   <= cfg_data;
                CFG_STUCK_TIMEOUT: stuck_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign pulse_load = TIMER_BITS'(relay_pulse_reg);
    assign stuck_load = TIMER_BITS'(stuck_timeout_reg);

    assign s_accept = s_tvalid && s_tready;
    assign sw       = {s_tdata[3], s_tdata[2]};

    drc_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (s_accept),
        .op              (s_tuser),
        .cmd             (s_tdata[1:0]),
        .sw              (sw),
        .stuck_load_zero (stuck_load == '0),
        .pulse_st        (pulse_st),
        .stuck_st        (stuck_st),
        .lost_st         (lost_st),
        .pulse_ctl       (pulse_ctl),
        .stuck_ctl       (stuck_ctl),
        .lost_ctl        (lost_ctl),
        .result          (result)
    );

    drc_timer #(.TIMER_BITS(TIMER_BITS)) u_pulse_timer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (pulse_ctl),
        .load_value (pulse_load),
        .status_adv (pulse_st)
    );

    drc_timer #(.TIMER_BITS(TIMER_BITS)) u_stuck_timer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (stuck_ctl),
        .load_value (stuck_load),
        .status_adv (stuck_st)
    );

    // Lost-switch timer shares the stuck timeout
    drc_timer #(.TIMER_BITS(TIMER_BITS)) u_lost_timer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (lost_ctl),
        .load_value (stuck_load),
        .status_adv (lost_st)
    );

    drc_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_accept),
        .push_data (result),
        .ready     (s_tready),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (m_result)
    );

    assign m_tdata = {3'b000, m_result.response, m_result.door_status,
                      m_result.relay_drive};

    // A skid entry only exists behind a held output entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("result buffer full without a valid output");

    // Ticks never get a negative response
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == OP_TICK) |-> result.response == RESP_ACK)
        else $error("nak response on a tick");

    // Both switches active on a tick: relay off and status unknown
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == OP_TICK && sw == SW_BOTH) |->
            (!result.relay_drive && result.door_status == MODE_UNKNOWN))
        else $error("relay or status wrong with both switches active");

    // An accepted invalid command on an empty output leaves a nak invalid result there in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser == OP_COMMAND && s_tdata[1] && !m_tvalid) |=>
            (m_tvalid && m_result.response == RESP_NAK_INVALID))
        else $error("invalid command not reported");

endmodule

`default_nettype wire

// File: rtl/core/drc_timer.sv
// Down-counting tick timer with not-set / running / expired status.
// Depends on drc_pkg for the status type and the control struct.
`default_nettype none

module drc_timer #(
    parameter int TIMER_BITS = drc_pkg::TIMER_BITS_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire drc_pkg::tmr_ctl_t     ctl,
    input  wire logic [TIMER_BITS-1:0] load_value,
    output drc_pkg::tmr_status_t       status_adv
);
    import drc_pkg::*;

    tmr_status_t           status_reg, status_next;
    logic [TIMER_BITS-1:0] count_reg, count_next;
    logic [TIMER_BITS-1:0] count_adv;

    // Status and count as they stand after one tick; taken only when advancing
    always_comb begin
        count_adv  = count_reg;
        status_adv = status_reg;
        if (status_reg == TMR_RUNNING) begin
            if (count_reg != '0) begin
                count_adv = count_reg - TIMER_BITS'(1);
            end
            if (count_adv == '0) begin
                status_adv = TMR_EXPIRED;
            end
        end
    end

    always_comb begin
        if (ctl.start) begin
            count_next  = load_value;
            status_next = (load_value == '0) ? TMR_EXPIRED : TMR_RUNNING;
        end else if (ctl.clear) begin
            count_next  = '0;
            status_next = TMR_NOTSET;
        end else if (ctl.advance) begin
            count_next  = count_adv;
            status_next = status_adv;
        end else begin
            count_next  = count_reg;
            status_next = status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= TMR_NOTSET;
            count_reg  <= '0;
        end else begin
            status_reg <= status_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/drc_ctrl.sv
// Door mode, seek phase and relay state; decides one accepted tick or command per cycle.
// Depends on drc_pkg; drives the three drc_timer instances of the top level.
`default_nettype none

module drc_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 accept,
    input  wire logic                 op,
    input  wire logic [1:0]           cmd,
    input  wire logic [1:0]           sw,
    input  wire logic                 stuck_load_zero,
    input  wire drc_pkg::tmr_status_t pulse_st,
    input  wire drc_pkg::tmr_status_t stuck_st,
    input  wire drc_pkg::tmr_status_t lost_st,
    output drc_pkg::tmr_ctl_t         pulse_ctl,
    output drc_pkg::tmr_ctl_t         stuck_ctl,
    output drc_pkg::tmr_ctl_t         lost_ctl,
    output drc_pkg::result_t          result
);
    import drc_pkg::*;

    door_mode_t mode_reg, mode_next;
    logic       seeking_reg, seeking_next;
    logic       seek_pulse_reg, seek_pulse_next;
    logic [1:0] last_req_reg, last_req_next;
    logic       relay_reg, relay_next;
    resp_t      resp;
    logic       stuck_expired;

    always_comb begin
        mode_next       = mode_reg;
        seeking_next    = seeking_reg;
        seek_pulse_next = seek_pulse_reg;
        last_req_next   = last_req_reg;
        relay_next      = relay_reg;
        resp            = RESP_ACK;
        pulse_ctl       = '0;
        stuck_ctl       = '0;
        lost_ctl        = '0;
        stuck_expired   = 1'b0;

        if (accept && op == OP_TICK) begin
            pulse_ctl.advance = 1'b1;
            stuck_ctl.advance = 1'b1;
            lost_ctl.advance  = 1'b1;

            if (sw == SW_BOTH) begin
                relay_next = 1'b0;
            end else if (pulse_st != TMR_RUNNING) begin
                if (pulse_st == TMR_EXPIRED) begin
                    pulse_ctl.clear = 1'b1;
                    relay_next      = 1'b0;
                end

                if (seeking_reg) begin
                    stuck_expired = (stuck_st == TMR_EXPIRED);
                    if (sw == SW_NONE && !seek_pulse_reg) begin
                        pulse_ctl.start = 1'b1;
                        pulse_ctl.clear = 1'b0;
                        relay_next      = 1'b1;
                        mode_next       = MODE_UNKNOWN;
                        stuck_ctl.start = 1'b1;
                        seek_pulse_next = 1'b1;
                        stuck_expired   = stuck_load_zero;
                    end
                    if (sw == SW_OPEN) begin
                        mode_next       = MODE_OPEN;
                        seeking_next    = 1'b0;
                        stuck_ctl.start = 1'b0;
                        stuck_ctl.clear = 1'b1;
                    end else if (sw == SW_CLOSED) begin
                        mode_next       = MODE_CLOSED;
                        seeking_next    = 1'b0;
                        stuck_ctl.start = 1'b0;
                        stuck_ctl.clear = 1'b1;
                    end else if (stuck_expired) begin
                        mode_next       = MODE_UNKNOWN;
                        seeking_next    = 1'b0;
                        stuck_ctl.start = 1'b0;
                        stuck_ctl.clear = 1'b1;
                    end
                end else if (mode_reg == MODE_MOVING) begin
                    if (last_req_reg == CMD_OPEN && sw == SW_OPEN) begin
                        mode_next       = MODE_OPEN;
                        stuck_ctl.clear = 1'b1;
                    end else if (last_req_reg == CMD_CLOSE && sw == SW_CLOSED) begin
                        mode_next       = MODE_CLOSED;
                        stuck_ctl.clear = 1'b1;
                    end else if (stuck_st == TMR_EXPIRED) begin
                        mode_next       = MODE_UNKNOWN;
                        stuck_ctl.clear = 1'b1;
                    end
                end else begin
                    // Follow spontaneous changes between the two ends; from unknown, take up either end
                    case (mode_reg)
                        MODE_OPEN: begin
                            if (sw == SW_CLOSED) mode_next = MODE_CLOSED;
                        end
                        MODE_CLOSED: begin
                            if (sw == SW_OPEN) mode_next = MODE_OPEN;
                        end
                        default: begin
                            if (sw == SW_OPEN) mode_next = MODE_OPEN;
                            if (sw == SW_CLOSED) mode_next = MODE_CLOSED;
                        end
                    endcase

                    if (sw == SW_NONE) begin
                        if (lost_st == TMR_NOTSET) begin
                            lost_ctl.start = 1'b1;
                        end else if (lost_st == TMR_EXPIRED) begin
                            lost_ctl.clear = 1'b1;
                            mode_next      = MODE_UNKNOWN;
                        end
                    end else begin
                        lost_ctl.clear = 1'b1;
                    end
                end
            end
        end else if (accept) begin
            if (cmd != CMD_OPEN && cmd != CMD_CLOSE) begin
                resp = RESP_NAK_INVALID;
            end else if (seeking_reg) begin
                last_req_next = cmd;
            end else if (!(mode_reg inside {MODE_OPEN, MODE_CLOSED})) begin
                resp = RESP_NAK_NOT_READY;
            end else if ((mode_reg == MODE_CLOSED && cmd == CMD_OPEN) ||
                         (mode_reg == MODE_OPEN && cmd == CMD_CLOSE)) begin
                last_req_next   = cmd;
                pulse_ctl.start = 1'b1;
                relay_next      = 1'b1;
                mode_next       = MODE_MOVING;
                stuck_ctl.start = 1'b1;
            end
        end
    end

    always_comb begin
        result.relay_drive = relay_next;
        result.door_status = (sw == SW_BOTH) ? MODE_UNKNOWN : mode_next;
        result.response    = resp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_UNKNOWN;
            seeking_reg    <= 1'b1;
            seek_pulse_reg <= 1'b0;
            last_req_reg   <= REQ_NONE;
            relay_reg      <= 1'b0;
        end else begin
            mode_reg       <= mode_next;
            seeking_reg    <= seeking_next;
            seek_pulse_reg <= seek_pulse_next;
            last_req_reg   <= last_req_next;
            relay_reg      <= relay_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/drc_outbuf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on drc_pkg for the result struct.
`default_nettype none

module drc_outbuf (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire drc_pkg::result_t push_data,
    output logic                  ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output drc_pkg::result_t      m_data
);
    import drc_pkg::*;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_data_reg, skid_data_reg;
    logic    pop;

    assign pop     = out_valid_reg && m_ready;
    assign ready   = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload: advance skid into output, or capture the new transaction
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) out_data_reg <= skid_data_reg;
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_reg <= push_data;
            end else begin
                skid_data_reg <= push_data;
            end
        end
    end

endmodule

`default_nettype wire
